[design/assert_macros.svh]
// Assertion macros shared by the lattice neighbor offset block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[design/lno_pkg.sv]
// Shared types, widths and codes for the lattice neighbor offset block.
package lno_pkg;

    localparam int INDEX_BITS    = 20;
    localparam int POS_BITS      = 32;
    localparam int KIND_BITS     = 2;
    localparam int LEN_BITS      = 11;
    localparam int FILL_BITS     = 20;
    localparam int PITCH_BITS    = 31;
    localparam int SURF_BITS     = 3;
    localparam int CFG_ADDR_BITS = 3;
    // signed neighbor index: cell index plus or minus one plane
    localparam int DELTA_BITS    = 2 * LEN_BITS + 2;
    // divider partial remainder
    localparam int REM_BITS      = LEN_BITS + 1;
    localparam int QUEUE_DEPTH_DEF = 4;

    // lattice kinds
    localparam logic [KIND_BITS-1:0] LATTICE_RECT = 2'd1;
    localparam logic [KIND_BITS-1:0] LATTICE_HEX  = 2'd2;

    // rectangular faces
    localparam logic [SURF_BITS-1:0] FACE_X_MINUS = 3'd1;
    localparam logic [SURF_BITS-1:0] FACE_X_PLUS  = 3'd2;
    localparam logic [SURF_BITS-1:0] FACE_Y_MINUS = 3'd3;
    localparam logic [SURF_BITS-1:0] FACE_Y_PLUS  = 3'd4;
    localparam logic [SURF_BITS-1:0] FACE_Z_MINUS = 3'd5;
    localparam logic [SURF_BITS-1:0] FACE_Z_PLUS  = 3'd6;

    // hexagonal sides
    localparam logic [SURF_BITS-1:0] HEX_FA = 3'd1;
    localparam logic [SURF_BITS-1:0] HEX_AB = 3'd2;
    localparam logic [SURF_BITS-1:0] HEX_BC = 3'd3;
    localparam logic [SURF_BITS-1:0] HEX_CD = 3'd4;
    localparam logic [SURF_BITS-1:0] HEX_DE = 3'd5;
    localparam logic [SURF_BITS-1:0] HEX_EF = 3'd6;

    // register reset values
    localparam logic [KIND_BITS-1:0]  RST_LATTICE_KIND = LATTICE_RECT;
    localparam logic [LEN_BITS-1:0]   RST_ROW_LENGTH   = 11'd1;
    localparam logic [LEN_BITS-1:0]   RST_COL_LENGTH   = 11'd1;
    localparam logic [FILL_BITS-1:0]  RST_FILLED_COUNT = 20'd1;
    localparam logic [PITCH_BITS-1:0] RST_PITCH        = 31'd65536;
    localparam logic [PITCH_BITS-1:0] RST_HEX_HEIGHT   = 31'd56756;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_LATTICE_KIND  = 3'd0,
        REG_ROW_LENGTH    = 3'd1,
        REG_COLUMN_LENGTH = 3'd2,
        REG_FILLED_COUNT  = 3'd3,
        REG_PITCH_X       = 3'd4,
        REG_PITCH_Y       = 3'd5,
        REG_PITCH_Z       = 3'd6,
        REG_HEX_HEIGHT    = 3'd7
    } lno_reg_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]      cell_index;
        logic [SURF_BITS-1:0]       surface;
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic signed [POS_BITS-1:0] pos_z;
    } lno_in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]      new_index;
        logic                       index_valid;
        logic signed [POS_BITS-1:0] new_x;
        logic signed [POS_BITS-1:0] new_y;
        logic signed [POS_BITS-1:0] new_z;
    } lno_out_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  lattice_kind;
        logic [LEN_BITS-1:0]   row_length;
        logic [LEN_BITS-1:0]   column_length;
        logic [FILL_BITS-1:0]  filled_count;
        logic [PITCH_BITS-1:0] pitch_x;
        logic [PITCH_BITS-1:0] pitch_y;
        logic [PITCH_BITS-1:0] pitch_z;
        logic [PITCH_BITS-1:0] hex_height;
    } lno_cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [INDEX_BITS-1:0]        idx;
        logic signed [DELTA_BITS-1:0] delta;
        logic                         base_ok;
        logic                         is_hex;
        logic                         dc_neg;
        logic                         dc_pos;
        logic                         dr_neg;
        logic                         dr_pos;
        logic signed [POS_BITS-1:0]   x;
        logic signed [POS_BITS-1:0]   y;
        logic signed [POS_BITS-1:0]   z;
    } lno_cls_t;

endpackage

[design/lattice_neighbor_offset_core.sv]
// Top level of the lattice neighbor offset block: registers, front end, queue and back end.
//
// Use: an item on s_ (cell index, crossed face, Q16.16 position) gives exactly one result
// on m_ (neighbor index, valid flag, shifted and saturated position), in order. Both
// channels are valid/ready; an item moves at a clock edge with valid and ready both high.
// The cfg_ channel writes one register per item (cfg_addr selects it, cfg_data holds the
// value, low bits used); cfg_ready is always high. Write registers only while idle.
// Path: from acceptance an item passes the front slot, the queue and the row divider
// pipeline (one quotient bit per stage), whose last stage feeds the output register.
// Throughput: one item per cycle while m_ready does not hold back a result, set by the
// divider pipeline, which advances as one unit.
// Stall: when m_ready is low with a result held, the divider pipeline freezes, the
// queue (QUEUE_DEPTH items) fills, then the front slot, and then s_ready drops.
// Reset (aresetn low, synchronous): all pipeline and queue entries are emptied and the
// registers return to rectangular mode, unit row/column lengths, filled count 1,
// pitches of 1.0 and hexagon height of about 0.866.
module lattice_neighbor_offset_core #(
    parameter int QUEUE_DEPTH = lno_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lno_pkg::lno_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lno_pkg::lno_out_t                 m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lno_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [lno_pkg::PITCH_BITS-1:0]    cfg_data
);
    import lno_pkg::*;

`include "assert_macros.svh"

    lno_cfg_t cfg_reg;
    logic     front_valid;
    logic     front_ready;
    lno_cls_t front_data;
    logic     back_valid;
    logic     back_ready;
    lno_cls_t back_data;
    logic     res_void;
    logic     res_live;
    logic     res_in_range;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lattice_kind  <= RST_LATTICE_KIND;
            cfg_reg.row_length    <= RST_ROW_LENGTH;
            cfg_reg.column_length <= RST_COL_LENGTH;
            cfg_reg.filled_count  <= RST_FILLED_COUNT;
            cfg_reg.pitch_x       <= RST_PITCH;
            cfg_reg.pitch_y       <= RST_PITCH;
            cfg_reg.pitch_z       <= RST_PITCH;
            cfg_reg.hex_height    <= RST_HEX_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (lno_reg_t'(cfg_addr))
                REG_LATTICE_KIND:  cfg_reg.lattice_kind  <= cfg_data[KIND_BITS-1:0];
                REG_ROW_LENGTH:    cfg_reg.row_length    <= cfg_data[LEN_BITS-1:0];
                REG_COLUMN_LENGTH: cfg_reg.column_length <= cfg_data[LEN_BITS-1:0];
                REG_FILLED_COUNT:  cfg_reg.filled_count  <= cfg_data[FILL_BITS-1:0];
                REG_PITCH_X:       cfg_reg.pitch_x       <= cfg_data;
                REG_PITCH_Y:       cfg_reg.pitch_y       <= cfg_data;
                REG_PITCH_Z:       cfg_reg.pitch_z       <= cfg_data;
                REG_HEX_HEIGHT:    cfg_reg.hex_height    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    lno_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cls_valid (front_valid),
        .cls_data  (front_data),
        .cls_ready (front_ready)
    );

    lno_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_data)
    );

    lno_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (back_valid),
        .in_ready (back_ready),
        .in_data  (back_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // result classes used by the checks
    assign res_void     = m_valid && !m_data.index_valid;
    assign res_live     = m_valid && m_data.index_valid;
    assign res_in_range = (m_data.new_index != '0)
                       && (m_data.new_index <= cfg_reg.filled_count);

    // checks
    `ASSERT_IMP(a_invalid_index_zero, aclk, aresetn, res_void, m_data.new_index == '0)
    `ASSERT_IMP(a_valid_index_in_range, aclk, aresetn, res_live, res_in_range)
    `ASSERT_IMP(a_input_stall_has_cause, aclk, aresetn, !s_ready, front_valid && !front_ready)
    `ASSERT_NEXT(a_front_holds_item, aclk, aresetn, front_valid && !front_ready, front_valid)

endmodule

[design/lno_front.sv]
// Front end: accepts items, decodes the face, shifts the position and forms the index step.
module lno_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  lno_pkg::lno_cfg_t cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  lno_pkg::lno_in_t  s_data,
    output logic              cls_valid,
    output lno_pkg::lno_cls_t cls_data,
    input  logic              cls_ready
);
    import lno_pkg::*;

    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic signed [DELTA_BITS-1:0] DELTA_ONE = DELTA_BITS'(1);

    // saturating add of an unsigned magnitude, subtracted when neg is set
    function automatic logic signed [POS_BITS-1:0] sat_add(
        input logic signed [POS_BITS-1:0] p,
        input logic [PITCH_BITS-1:0]      mag,
        input logic                       neg
    );
        logic signed [POS_BITS:0] ext_p;
        logic signed [POS_BITS:0] ext_d;
        logic signed [POS_BITS:0] sum;
        logic signed [POS_BITS-1:0] res;
        ext_p = {p[POS_BITS-1], p};
        ext_d = {{(POS_BITS+1-PITCH_BITS){1'b0}}, mag};
        sum   = neg ? (ext_p - ext_d) : (ext_p + ext_d);
        if (sum[POS_BITS] != sum[POS_BITS-1]) begin
            res = sum[POS_BITS] ? POS_MIN : POS_MAX;
        end else begin
            res = sum[POS_BITS-1:0];
        end
        return res;
    endfunction

    logic                         slot_valid_reg;
    lno_cls_t                     slot_data_reg;
    lno_cls_t                     cls_next;
    logic [2*LEN_BITS-1:0]        plane;
    logic signed [DELTA_BITS-1:0] row_ext;
    logic signed [DELTA_BITS-1:0] plane_ext;
    logic [PITCH_BITS-1:0]        half_x;
    logic [PITCH_BITS-1:0]        mag_x;
    logic [PITCH_BITS-1:0]        mag_y;
    logic [PITCH_BITS-1:0]        mag_z;
    logic                         neg_x;
    logic                         neg_y;
    logic                         neg_z;
    logic                         idx_ok;

    // face decode
    always_comb begin
        plane = {{LEN_BITS{1'b0}}, cfg.row_length} * {{LEN_BITS{1'b0}}, cfg.column_length};
        row_ext   = $signed({{(DELTA_BITS-LEN_BITS){1'b0}}, cfg.row_length});
        plane_ext = $signed({{(DELTA_BITS-2*LEN_BITS){1'b0}}, plane});
        half_x    = {1'b0, cfg.pitch_x[PITCH_BITS-1:1]};
        idx_ok    = (s_data.cell_index != '0) && (cfg.row_length != '0);
        mag_x = '0;
        mag_y = '0;
        mag_z = '0;
        neg_x = 1'b0;
        neg_y = 1'b0;
        neg_z = 1'b0;
        cls_next.idx     = s_data.cell_index;
        cls_next.delta   = '0;
        cls_next.base_ok = 1'b0;
        cls_next.is_hex  = 1'b0;
        cls_next.dc_neg  = 1'b0;
        cls_next.dc_pos  = 1'b0;
        cls_next.dr_neg  = 1'b0;
        cls_next.dr_pos  = 1'b0;
        unique case (cfg.lattice_kind)
            LATTICE_RECT: begin
                cls_next.base_ok = idx_ok;
                unique case (s_data.surface)
                    FACE_X_MINUS: begin
                        cls_next.delta = -DELTA_ONE;
                        mag_x = cfg.pitch_x;
                    end
                    FACE_X_PLUS: begin
                        cls_next.delta = DELTA_ONE;
                        mag_x = cfg.pitch_x;
                        neg_x = 1'b1;
                    end
                    FACE_Y_MINUS: begin
                        cls_next.delta = -row_ext;
                        mag_y = cfg.pitch_y;
                    end
                    FACE_Y_PLUS: begin
                        cls_next.delta = row_ext;
                        mag_y = cfg.pitch_y;
                        neg_y = 1'b1;
                    end
                    FACE_Z_MINUS: begin
                        cls_next.delta = -plane_ext;
                        mag_z = cfg.pitch_z;
                    end
                    FACE_Z_PLUS: begin
                        cls_next.delta = plane_ext;
                        mag_z = cfg.pitch_z;
                        neg_z = 1'b1;
                    end
                    default: begin
                        cls_next.base_ok = 1'b0;
                    end
                endcase
            end
            LATTICE_HEX: begin
                cls_next.base_ok = idx_ok;
                cls_next.is_hex  = 1'b1;
                unique case (s_data.surface)
                    HEX_FA: begin
                        cls_next.dc_neg = 1'b1;
                        mag_x = cfg.pitch_x;
                    end
                    HEX_AB: begin
                        cls_next.dr_neg = 1'b1;
                        mag_x = half_x;
                        mag_y = cfg.hex_height;
                    end
                    HEX_BC: begin
                        cls_next.dc_pos = 1'b1;
                        cls_next.dr_neg = 1'b1;
                        mag_x = half_x;
                        neg_x = 1'b1;
                        mag_y = cfg.hex_height;
                    end
                    HEX_CD: begin
                        cls_next.dc_pos = 1'b1;
                        mag_x = cfg.pitch_x;
                        neg_x = 1'b1;
                    end
                    HEX_DE: begin
                        cls_next.dr_pos = 1'b1;
                        mag_x = half_x;
                        neg_x = 1'b1;
                        mag_y = cfg.hex_height;
                        neg_y = 1'b1;
                    end
                    HEX_EF: begin
                        cls_next.dc_neg = 1'b1;
                        cls_next.dr_pos = 1'b1;
                        mag_x = half_x;
                        mag_y = cfg.hex_height;
                        neg_y = 1'b1;
                    end
                    default: begin
                        // no move: the current cell itself is checked
                    end
                endcase
                // step = column change plus row change times row length
                cls_next.delta = (cls_next.dc_pos ? DELTA_ONE : '0)
                               - (cls_next.dc_neg ? DELTA_ONE : '0)
                               + (cls_next.dr_pos ? row_ext : '0)
                               - (cls_next.dr_neg ? row_ext : '0);
            end
            default: begin
                // unknown kind: invalid, position unchanged
            end
        endcase
        cls_next.x = sat_add(s_data.pos_x, mag_x, neg_x);
        cls_next.y = sat_add(s_data.pos_y, mag_y, neg_y);
        cls_next.z = sat_add(s_data.pos_z, mag_z, neg_z);
    end

    assign s_ready   = !slot_valid_reg || cls_ready;
    assign cls_valid = slot_valid_reg;
    assign cls_data  = slot_data_reg;

    // output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= 1'b0;
        end else if (s_ready) begin
            slot_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            slot_data_reg <= cls_next;
        end
    end

endmodule

[design/lno_queue.sv]
// Small FIFO between the front end and the divider pipeline.
module lno_queue #(
    parameter int DEPTH = lno_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lno_pkg::lno_cls_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lno_pkg::lno_cls_t out_data
);
    import lno_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    lno_cls_t            entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[design/lno_back.sv]
// Back end: pipelined row divider, hexagonal bounds check, index range check, output register.
module lno_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  lno_pkg::lno_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  lno_pkg::lno_cls_t in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lno_pkg::lno_out_t m_data
);
    import lno_pkg::*;

    // one quotient bit per stage
    localparam int STAGES = INDEX_BITS;

    typedef struct packed {
        lno_cls_t              item;
        logic [REM_BITS-1:0]   rem;
        logic [INDEX_BITS-1:0] work;
    } lno_stage_t;

    // one restoring step: shift a dividend bit in, subtract if it fits
    function automatic lno_stage_t div_step(
        input lno_stage_t          cur,
        input logic [LEN_BITS-1:0] divisor
    );
        logic [REM_BITS-1:0] trial;
        lno_stage_t          nxt;
        nxt   = cur;
        trial = {cur.rem[REM_BITS-2:0], cur.work[INDEX_BITS-1]};
        if (trial >= {1'b0, divisor}) begin
            nxt.rem  = trial - {1'b0, divisor};
            nxt.work = {cur.work[INDEX_BITS-2:0], 1'b1};
        end else begin
            nxt.rem  = trial;
            nxt.work = {cur.work[INDEX_BITS-2:0], 1'b0};
        end
        return nxt;
    endfunction

    lno_stage_t                   stage_reg [STAGES];
    logic [STAGES-1:0]            stage_valid_reg;
    logic                         m_valid_reg;
    lno_out_t                     m_data_reg;
    logic                         adv;
    lno_stage_t                   entry;
    lno_stage_t                   fin;
    logic [REM_BITS:0]            c_adj;
    logic [INDEX_BITS:0]          r_adj;
    logic                         c_ok;
    logic                         r_ok;
    logic signed [DELTA_BITS-1:0] nidx;
    logic signed [DELTA_BITS-1:0] filled_ext;
    logic                         ok;
    lno_out_t                     result_next;

    // whole pipeline moves when the output register is free or being taken
    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        entry.item = in_data;
        entry.rem  = '0;
        entry.work = in_data.idx - 1'b1;
    end

    // final checks on the last divider stage
    always_comb begin
        fin   = stage_reg[STAGES-1];
        c_adj = {1'b0, fin.rem} + {{REM_BITS{1'b0}}, fin.item.dc_pos}
              - {{REM_BITS{1'b0}}, fin.item.dc_neg};
        r_adj = {1'b0, fin.work} + {{INDEX_BITS{1'b0}}, fin.item.dr_pos}
              - {{INDEX_BITS{1'b0}}, fin.item.dr_neg};
        // a step below zero wraps high and fails the upper bound too
        c_ok  = c_adj < {2'b00, cfg.row_length};
        r_ok  = r_adj < {{(INDEX_BITS+1-LEN_BITS){1'b0}}, cfg.column_length};
        nidx  = $signed({{(DELTA_BITS-INDEX_BITS){1'b0}}, fin.item.idx}) + fin.item.delta;
        filled_ext = $signed({{(DELTA_BITS-FILL_BITS){1'b0}}, cfg.filled_count});
        ok = fin.item.base_ok && (!fin.item.is_hex || (c_ok && r_ok))
           && (nidx > $signed(DELTA_BITS'(0))) && (nidx <= filled_ext);
        result_next.new_index   = ok ? nidx[INDEX_BITS-1:0] : '0;
        result_next.index_valid = ok;
        result_next.new_x       = fin.item.x;
        result_next.new_y       = fin.item.y;
        result_next.new_z       = fin.item.z;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else if (adv) begin
            stage_valid_reg <= {stage_valid_reg[STAGES-2:0], in_valid};
            m_valid_reg     <= stage_valid_reg[STAGES-1];
        end
    end

    // divider stages and output payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg[0] <= div_step(entry, cfg.row_length);
            for (int s = 1; s < STAGES; s++) begin
                stage_reg[s] <= div_step(stage_reg[s-1], cfg.row_length);
            end
            m_data_reg <= result_next;
        end
    end

endmodule
